// ===== rtl/sbrl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the size bounded recency list.
// No dependencies.
package sbrl_pkg;

	localparam int LIST_DEPTH_DEF = 64;
	localparam int ID_SPACE_DEF   = 1024;
	localparam int ID_W           = 10;
	localparam int SIZE_W         = 16;
	localparam int CAP_W          = 20;
	localparam int TOTAL_W        = 21;
	localparam int ACT_W          = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_REPORT = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_FULL_CHK,
		ST_FULL_SUB,
		ST_APPEND,
		ST_EVICT_CHK,
		ST_EVICT_SUB,
		ST_REPORT_RD,
		ST_REPORT_OUT,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [ID_W-1:0]   id;
	} entry_t;

endpackage

// ===== rtl/size_bounded_recency_list_core.sv =====
`timescale 1ns / 1ps
// Size bounded recency list: list memory, sequencer and stream ports.
// Depends on sbrl_pkg.
//
// The list lives in one synchronous memory of LIST_DEPTH entries kept as a ring, oldest entry at
// the ring tail; a sequencer walks it one entry at a time. Insert and remove search the list and
// close a gap by shifting newer entries down; an insert then appends and evicts from the tail
// while the total exceeds the capacity. Report emits one transfer per resident entry, newest
// first, reading each entry only once the output register is free; an empty list yields a single
// transfer with list_empty set. Clear empties the list when taken. Input is taken only while the
// sequencer is idle; the output register lets the last result wait without blocking.
module size_bounded_recency_list_core
	import sbrl_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF,
	parameter int ID_SPACE   = ID_SPACE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // item_id [9:0], item_size [25:10], zero [31:26]
	input  logic [ACT_W-1:0] s_tuser,   // action [1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // entry_id [9:0], zero [15:10]
	output logic             m_tuser,   // list_empty [0]
	output logic             m_tlast
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);

	entry_t              mem_q [LIST_DEPTH];
	entry_t              rdata_q;
	logic                rd_en;
	logic [CW-1:0]       rd_pos;
	logic                wr_en;
	logic [CW-1:0]       wr_pos;
	entry_t              wr_data;

	state_t              state_q, state_d;
	action_t             act_q, act_d;
	logic [ID_W-1:0]     id_q, id_d;
	logic [SIZE_W-1:0]   size_q, size_d;
	logic [CAP_W-1:0]    cap_q;
	logic [AW-1:0]       tail_q, tail_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       pos_q, pos_d;
	logic [TOTAL_W-1:0]  total_q, total_d;
	logic                out_valid_q, out_valid_d;
	logic [ID_W-1:0]     out_id_q, out_id_d;
	logic                out_empty_q, out_empty_d;
	logic                out_last_q, out_last_d;
	logic                out_free;
	logic                in_range;
	logic [AW-1:0]       tail_inc;

	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] t, input logic [CW-1:0] p);
		logic [AW+1:0] s;
		s = {2'b00, t} + (AW+2)'(p);
		if (s >= (AW+2)'(LIST_DEPTH))
			s = s - (AW+2)'(LIST_DEPTH);
		return s[AW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[ring_addr(tail_q, wr_pos)] <= wr_data;
		if (rd_en)
			rdata_q <= mem_q[ring_addr(tail_q, rd_pos)];
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16-ID_W){1'b0}}, out_id_q};
	assign m_tuser  = out_empty_q;
	assign m_tlast  = out_last_q;
	assign out_free = !out_valid_q || m_tready;
	assign in_range = ({7'd0, s_tdata[ID_W-1:0]} < 17'(ID_SPACE));
	assign tail_inc = (tail_q == AW'(LIST_DEPTH - 1)) ? '0 : tail_q + AW'(1);

	always_comb begin
		state_d     = state_q;
		act_d       = act_q;
		id_d        = id_q;
		size_d      = size_q;
		tail_d      = tail_q;
		count_d     = count_q;
		pos_d       = pos_q;
		total_d     = total_q;
		out_valid_d = out_valid_q && !m_tready;
		out_id_d    = out_id_q;
		out_empty_d = out_empty_q;
		out_last_d  = out_last_q;
		rd_en       = 1'b0;
		rd_pos      = pos_q;
		wr_en       = 1'b0;
		wr_pos      = pos_q;
		wr_data     = rdata_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					act_d  = action_t'(s_tuser);
					id_d   = s_tdata[ID_W-1:0];
					size_d = s_tdata[ID_W+SIZE_W-1:ID_W];
					pos_d  = '0;
					case (action_t'(s_tuser))
						ACT_INSERT, ACT_REMOVE: begin
							if (!in_range)
								state_d = ST_IDLE;
							else if (count_q != '0)
								state_d = ST_SRCH_RD;
							else if (action_t'(s_tuser) == ACT_INSERT)
								state_d = ST_FULL_CHK;
							else
								state_d = ST_IDLE;
						end
						ACT_REPORT: begin
							if (count_q == '0) begin
								state_d = ST_EMPTY;
							end else begin
								pos_d   = count_q - CW'(1);
								state_d = ST_REPORT_RD;
							end
						end
						default: begin
							count_d = '0;
							total_d = '0;
						end
					endcase
				end
			end
			ST_SRCH_RD: begin
				rd_en   = 1'b1;
				state_d = ST_SRCH_CHK;
			end
			ST_SRCH_CHK: begin
				if (rdata_q.id == id_q) begin
					total_d = total_q - TOTAL_W'(rdata_q.size);
					if (pos_q + CW'(1) < count_q) begin
						state_d = ST_SHIFT_RD;
					end else begin
						count_d = count_q - CW'(1);
						state_d = (act_q == ACT_INSERT) ? ST_FULL_CHK : ST_IDLE;
					end
				end else begin
					pos_d = pos_q + CW'(1);
					if (pos_q + CW'(1) < count_q)
						state_d = ST_SRCH_RD;
					else
						state_d = (act_q == ACT_INSERT) ? ST_FULL_CHK : ST_IDLE;
				end
			end
			ST_SHIFT_RD: begin
				rd_en   = 1'b1;
				rd_pos  = pos_q + CW'(1);
				state_d = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				wr_en = 1'b1;
				pos_d = pos_q + CW'(1);
				if ((CW+1)'(pos_q) + (CW+1)'(2) < (CW+1)'(count_q)) begin
					state_d = ST_SHIFT_RD;
				end else begin
					count_d = count_q - CW'(1);
					state_d = (act_q == ACT_INSERT) ? ST_FULL_CHK : ST_IDLE;
				end
			end
			ST_FULL_CHK: begin
				if (count_q == CW'(LIST_DEPTH)) begin
					rd_en   = 1'b1;
					rd_pos  = '0;
					state_d = ST_FULL_SUB;
				end else begin
					state_d = ST_APPEND;
				end
			end
			ST_FULL_SUB: begin
				total_d = total_q - TOTAL_W'(rdata_q.size);
				tail_d  = tail_inc;
				count_d = count_q - CW'(1);
				state_d = ST_APPEND;
			end
			ST_APPEND: begin
				wr_en        = 1'b1;
				wr_pos       = count_q;
				wr_data.id   = id_q;
				wr_data.size = size_q;
				count_d      = count_q + CW'(1);
				total_d      = total_q + TOTAL_W'(size_q);
				state_d      = ST_EVICT_CHK;
			end
			ST_EVICT_CHK: begin
				if (total_q > {1'b0, cap_q} && count_q != '0) begin
					rd_en   = 1'b1;
					rd_pos  = '0;
					state_d = ST_EVICT_SUB;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EVICT_SUB: begin
				total_d = total_q - TOTAL_W'(rdata_q.size);
				tail_d  = tail_inc;
				count_d = count_q - CW'(1);
				state_d = ST_EVICT_CHK;
			end
			ST_REPORT_RD: begin
				if (out_free) begin
					rd_en   = 1'b1;
					state_d = ST_REPORT_OUT;
				end
			end
			ST_REPORT_OUT: begin
				out_valid_d = 1'b1;
				out_id_d    = rdata_q.id;
				out_empty_d = 1'b0;
				out_last_d  = (pos_q == '0);
				if (pos_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					pos_d   = pos_q - CW'(1);
					state_d = ST_REPORT_RD;
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_id_d    = '0;
					out_empty_d = 1'b1;
					out_last_d  = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			total_q     <= total_d;
			out_valid_q <= out_valid_d;
			if (cfg_wr_en)
				cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		act_q       <= act_d;
		id_q        <= id_d;
		size_q      <= size_d;
		pos_q       <= pos_d;
		out_id_q    <= out_id_d;
		out_empty_q <= out_empty_d;
		out_last_q  <= out_last_d;
	end

endmodule

// ===== sim/size_bounded_recency_list_core_test.sv =====
`timescale 1ns / 1ps
// Testbench for size_bounded_recency_list_core: drives insert, remove, report and clear
// requests under random idling and checks every listing transfer against a built-in predictor.
// Depends on sbrl_pkg and size_bounded_recency_list_core.

typedef struct {
	logic [9:0] entry_id;
	logic       list_empty;
	logic       last;
} listing_t;

class recency_scoreboard;
	int unsigned capacity;
	int unsigned ids[64];
	int unsigned sizes[64];
	int unsigned count;
	int unsigned total;
	listing_t    listing_q[$];
	int          errors;

	function new();
		capacity = 0;
		count = 0;
		total = 0;
		errors = 0;
	endfunction

	function void drop_entry(int unsigned pos);
		if (pos < count) begin
			total -= sizes[pos];
			for (int unsigned i = pos; i + 1 < count; i++) begin
				ids[i] = ids[i + 1];
				sizes[i] = sizes[i + 1];
			end
			count--;
		end
	endfunction

	function void remove_entry(int unsigned id);
		for (int unsigned i = 0; i < count; i++) begin
			if (ids[i] == id) begin
				drop_entry(i);
				return;
			end
		end
	endfunction

	// predict the listing produced by one accepted request
	function void note_request(sbrl_pkg::action_t act, int unsigned id, int unsigned sz);
		listing_t l;
		case (act)
			sbrl_pkg::ACT_INSERT: begin
				remove_entry(id);
				if (count >= 64)
					drop_entry(count - 1);
				for (int unsigned i = count; i > 0; i--) begin
					ids[i] = ids[i - 1];
					sizes[i] = sizes[i - 1];
				end
				ids[0] = id;
				sizes[0] = sz;
				count++;
				total += sz;
				while (total > capacity && count > 0)
					drop_entry(count - 1);
			end
			sbrl_pkg::ACT_REMOVE: remove_entry(id);
			sbrl_pkg::ACT_REPORT: begin
				if (count == 0) begin
					l.entry_id = '0;
					l.list_empty = 1'b1;
					l.last = 1'b1;
					listing_q.push_back(l);
				end else begin
					for (int unsigned i = 0; i < count; i++) begin
						l.entry_id = ids[i];
						l.list_empty = 1'b0;
						l.last = (i + 1 == count);
						listing_q.push_back(l);
					end
				end
			end
			default: begin
				count = 0;
				total = 0;
			end
		endcase
	endfunction

	function void check_listing(logic [9:0] id, logic empty, logic last);
		listing_t e;
		if (listing_q.size() == 0) begin
			$display("%0t: unexpected transfer id=%0d empty=%0d last=%0d", $time, id, empty,
				last);
			errors++;
			return;
		end
		e = listing_q.pop_front();
		if (id !== e.entry_id) begin
			$display("%0t: entry_id expected %0d actual %0d", $time, e.entry_id, id);
			errors++;
		end
		if (empty !== e.list_empty) begin
			$display("%0t: list_empty expected %0d actual %0d", $time, e.list_empty, empty);
			errors++;
		end
		if (last !== e.last) begin
			$display("%0t: last expected %0d actual %0d", $time, e.last, last);
			errors++;
		end
	endfunction
endclass

module size_bounded_recency_list_core_test;
	import sbrl_pkg::*;

	localparam int DRAIN_CYCLES = 500;
	localparam int CYCLE_LIMIT  = 1000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [19:0] cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	recency_scoreboard sb = new();
	int tx_idle;
	int rx_idle;
	int hold_left;
	logic long_hold_req;
	logic long_hold_taken;
	int cycles;

	size_bounded_recency_list_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: check transfers, stall at random, take one long hold on request
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_listing(m_tdata[9:0], m_tuser, m_tlast);
		if (long_hold_req && !long_hold_taken) begin
			long_hold_taken <= 1'b1;
			hold_left <= 300;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send_request(action_t act, int unsigned id, int unsigned sz);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {6'b0, sz[15:0], id[9:0]};
		do @(posedge clk); while (!s_tready);
		sb.note_request(act, id, sz);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.listing_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(int unsigned cap);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap[19:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.capacity = cap;
	endtask

	task automatic send_random(int unsigned max_size);
		int r;
		int unsigned id;
		int unsigned sz;
		action_t act;
		r = $urandom_range(99);
		if (r < 55)
			act = ACT_INSERT;
		else if (r < 77)
			act = ACT_REMOVE;
		else if (r < 96)
			act = ACT_REPORT;
		else
			act = ACT_CLEAR;
		id = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(79);
		r = $urandom_range(19);
		if (r == 0)
			sz = 0;
		else if (r == 1)
			sz = 65535;
		else if (r < 5)
			sz = $urandom_range(65535);
		else
			sz = $urandom_range(max_size);
		send_request(act, id, sz);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_INSERT;
		m_tready = 1'b0;
		hold_left = 0;
		long_hold_req = 1'b0;
		long_hold_taken = 1'b0;
		cycles = 0;
		tx_idle = 0;
		rx_idle = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, duplicates, absent ids, clear
		set_capacity(20'hFFFFF);
		send_request(ACT_REPORT, 0, 0);
		send_request(ACT_INSERT, 0, 0);
		send_request(ACT_INSERT, 1023, 65535);
		send_request(ACT_INSERT, 5, 100);
		send_request(ACT_REPORT, 1023, 65535);
		send_request(ACT_INSERT, 0, 7);
		send_request(ACT_REMOVE, 77, 0);
		send_request(ACT_REPORT, 0, 0);
		send_request(ACT_REMOVE, 1023, 65535);
		send_request(ACT_REPORT, 0, 0);
		send_request(ACT_CLEAR, 1023, 65535);
		send_request(ACT_REPORT, 0, 0);
		set_capacity(0);
		send_request(ACT_INSERT, 3, 1);
		send_request(ACT_INSERT, 4, 0);
		send_request(ACT_REPORT, 0, 0);
		set_capacity(1000);
		send_request(ACT_INSERT, 10, 400);
		send_request(ACT_INSERT, 11, 500);
		send_request(ACT_INSERT, 12, 300);
		send_request(ACT_REPORT, 0, 0);
		send_request(ACT_INSERT, 13, 5000);
		send_request(ACT_REPORT, 0, 0);

		// random: sender sparse-ish, receiver mostly stalled; one long receiver hold
		tx_idle = 33;
		rx_idle = 85;
		set_capacity(20'hFFFFF);
		repeat (60) send_random(300);
		long_hold_req <= 1'b1;
		repeat (8) send_request(ACT_REPORT, 0, 0);
		repeat (60) send_random(65535);

		tx_idle = 85;
		rx_idle = 33;
		set_capacity($urandom_range(200000));
		repeat (125) send_random(8000);

		tx_idle = 0;
		rx_idle = 0;
		set_capacity(3000);
		repeat (125) send_random(120);

		drain();
		if (sb.listing_q.size() == 0 && sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/sbrl_pkg.sv
rtl/size_bounded_recency_list_core.sv
sim/size_bounded_recency_list_core_test.sv
